// ===== design/thbt_pkg.sv =====
// Shared constants and types for the thermistor Beta temperature pipeline.
`timescale 1ns / 1ps
package thbt_pkg;

  // Converter width that sets the reset full-scale code
  localparam int unsigned SAMPLE_BITS = 12;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPLY  = 3'd0,
    CFG_FSCALE  = 3'd1,
    CFG_RFIXED  = 3'd2,
    CFG_RNOM    = 3'd3,
    CFG_BETA    = 3'd4,
    CFG_T0      = 3'd5
  } cfg_idx_e;

  // Register reset values
  localparam logic [12:0] SUPPLY_RST = 13'd3300;
  localparam logic [15:0] FSCALE_RST = 16'((1 << SAMPLE_BITS) - 1);
  localparam logic [19:0] RFIXED_RST = 20'd10000;
  localparam logic [19:0] RNOM_RST   = 20'd10000;
  localparam logic [13:0] BETA_RST   = 14'd3950;
  localparam logic [15:0] T0_RST     = 16'd29815;

  // Arithmetic constants
  localparam logic [29:0] LN2_Q30       = 30'd744261118;
  localparam logic [16:0] KELVIN_OFFSET = 17'd27315;
  localparam logic [16:0] TEMP_HIGH     = 17'd65535;
  localparam logic [16:0] TEMP_LIMIT    = 17'd92850;  // offset plus high limit
  localparam logic [13:0] RATIO_SCALE   = 14'd10000;
  localparam logic [13:0] RATIO_TOP     = 14'd9999;

  // Pipeline depth by section
  localparam int unsigned DIV1_STEPS = 16;  // millivolt quotient bits
  localparam int unsigned LOG_STEPS  = 28;  // log2 fraction bits
  localparam int unsigned DIV2_STEPS = 17;  // kelvin quotient bits
  localparam int unsigned CLAMP_ST   = 2 + DIV1_STEPS;  // ratio clamp stage
  localparam int unsigned NUM_STAGES = 2 + DIV1_STEPS + 4 + LOG_STEPS + 6 + DIV2_STEPS + 1;

endpackage

// ===== design/thermistor_beta_temperature_top.sv =====
// Thermistor Beta-equation temperature converter, fully pipelined.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one raw converter word.
//   Output channel (out_valid_o / out_ready_i) returns one result word per
//   input: temperature in 0.01 degC, the sample in millivolts, and two flags.
//   A new word is taken every cycle unless a held output word stalls the pipe;
//   the depth comes from two restoring dividers (one quotient bit per stage),
//   a 28-stage log2 squaring chain per operand, and the multiply stages
//   around them.
//   Configuration registers are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i and must only change while the pipeline is empty.
//   Reset clears every valid bit and loads the default divider settings
//   (3.3 V supply, 12-bit converter, 10 k / 10 k, Beta 3950, 25 degC).
//   When the receiver stalls, the whole pipeline freezes in place and
//   in_ready_o drops; nothing is dropped or repeated, and the held result
//   stays stable on the output until taken.
`timescale 1ns / 1ps
module thermistor_beta_temperature_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [15:0]                         raw_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [16:0]                  temp_centi_celsius_o,
  output logic [15:0]                         sample_millivolts_o,
  output logic                                ratio_clamped_o,
  output logic                                result_saturated_o,
  input  logic                                cfg_we_i,
  input  logic [thbt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [thbt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import thbt_pkg::*;

  // Configuration registers
  logic [12:0] supply_q;
  logic [15:0] fscale_q;
  logic [19:0] rfixed_q;
  logic [19:0] rnom_q;
  logic [13:0] beta_q;
  logic [15:0] t0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= SUPPLY_RST;
      fscale_q <= FSCALE_RST;
      rfixed_q <= RFIXED_RST;
      rnom_q   <= RNOM_RST;
      beta_q   <= BETA_RST;
      t0_q     <= T0_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SUPPLY: supply_q <= cfg_data_i[12:0];
        CFG_FSCALE: fscale_q <= cfg_data_i[15:0];
        CFG_RFIXED: rfixed_q <= cfg_data_i;
        CFG_RNOM:   rnom_q   <= cfg_data_i;
        CFG_BETA:   beta_q   <= cfg_data_i[13:0];
        CFG_T0:     t0_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Config-only products, settled long before any word needs them
  logic [29:0] t0beta_q;
  logic [60:0] n_q;
  logic [44:0] bterm_q;
  logic        cfg_bad_q;

  always_ff @(posedge clk_i) begin
    t0beta_q  <= 30'(t0_q) * 30'(beta_q);
    n_q       <= (61'(t0beta_q) * 61'(100)) << 24;
    bterm_q   <= (45'(beta_q) * 45'(100)) << 24;
    cfg_bad_q <= (rfixed_q == '0) || (rnom_q == '0) || (beta_q == '0) || (t0_q == '0);
  end

  // Global advance: the whole pipe moves unless the output word is held
  logic adv;
  logic [NUM_STAGES-1:0] vld_q;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  // Stage: raw times supply
  logic [28:0] prod0_q;
  always_ff @(posedge clk_i) begin
    if (adv) prod0_q <= 29'(raw_sample_i) * 29'(supply_q);
  end

  // Stage: quotient overflow check, seeds the millivolt divider
  logic [28:0] d1_rem_q [DIV1_STEPS+1];
  logic [15:0] d1_quo_q [DIV1_STEPS+1];
  logic        d1_sat_q [DIV1_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_rem_q[0] <= prod0_q;
      d1_quo_q[0] <= '0;
      d1_sat_q[0] <= (fscale_q == '0) || (32'(prod0_q) >= {fscale_q, 16'b0});
    end
  end

  // Millivolt divider: one quotient bit per stage, MSB first
  for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
    logic [31:0] sub;
    logic        take;
    assign sub  = 32'(fscale_q) << (DIV1_STEPS - 1 - k);
    assign take = 32'(d1_rem_q[k]) >= sub;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d1_rem_q[k+1] <= take ? 29'(32'(d1_rem_q[k]) - sub) : d1_rem_q[k];
        d1_quo_q[k+1] <= d1_quo_q[k] | (take ? (16'd1 << (DIV1_STEPS - 1 - k)) : 16'd0);
        d1_sat_q[k+1] <= d1_sat_q[k];
      end
    end
  end

  // Stage: ratio clamp
  logic [15:0] mv;
  logic [29:0] mv10k;
  logic        ratio_lo;
  logic        ratio_hi;
  logic [15:0] mv_q [CLAMP_ST:NUM_STAGES-1];
  logic        clamp_q [CLAMP_ST:NUM_STAGES-1];
  logic [13:0] num_q;
  logic [13:0] dmn_q;

  assign mv       = d1_sat_q[DIV1_STEPS] ? 16'hFFFF : d1_quo_q[DIV1_STEPS];
  assign mv10k    = 30'(mv) * 30'(RATIO_SCALE);
  assign ratio_lo = (supply_q == '0) || (mv10k < 30'(supply_q));
  assign ratio_hi = mv10k > (30'(supply_q) * 30'(RATIO_TOP));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mv_q[CLAMP_ST]    <= mv;
      clamp_q[CLAMP_ST] <= ratio_lo || ratio_hi;
      if (ratio_lo) begin
        num_q <= 14'd1;
        dmn_q <= RATIO_TOP;
      end else if (ratio_hi) begin
        num_q <= RATIO_TOP;
        dmn_q <= 14'd1;
      end else begin
        num_q <= 14'(mv);
        dmn_q <= 14'(supply_q) - 14'(mv);
      end
    end
  end

  // Side fields ride along the remaining stages
  for (genvar s = CLAMP_ST + 1; s < NUM_STAGES; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        mv_q[s]    <= mv_q[s-1];
        clamp_q[s] <= clamp_q[s-1];
      end
    end
  end

  // Stage: resistance terms R_fixed*num and R_nom*(den-num)
  logic [33:0] va_q;
  logic [33:0] vb_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      va_q <= 34'(rfixed_q) * 34'(num_q);
      vb_q <= 34'(rnom_q) * 34'(dmn_q);
    end
  end

  // Stage: leading-one position
  function automatic logic [5:0] msb_pos(input logic [33:0] v);
    logic [5:0] e;
    e = '0;
    for (int i = 0; i < 34; i++) begin
      if (v[i]) e = 6'(i);
    end
    return e;
  endfunction

  logic [33:0] va2_q, vb2_q;
  logic [5:0]  ea_q, eb_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      va2_q <= va_q;
      vb2_q <= vb_q;
      ea_q  <= msb_pos(va_q);
      eb_q  <= msb_pos(vb_q);
    end
  end

  // Stage: normalize to Q1.30, integer part of log2
  logic [63:0] sha, shb;
  logic [30:0] ma_q [LOG_STEPS+1];
  logic [30:0] mb_q [LOG_STEPS+1];
  logic [33:0] ra_q [LOG_STEPS+1];
  logic [33:0] rb_q [LOG_STEPS+1];

  assign sha = (64'(va2_q) << 30) >> ea_q;
  assign shb = (64'(vb2_q) << 30) >> eb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ma_q[0] <= sha[30:0];
      mb_q[0] <= shb[30:0];
      ra_q[0] <= {ea_q, 28'b0};
      rb_q[0] <= {eb_q, 28'b0};
    end
  end

  // log2 fraction: square, one result bit per stage
  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
    logic [61:0] pa, pb;
    logic [31:0] ta, tb;
    assign pa = 62'(ma_q[j]) * 62'(ma_q[j]);
    assign pb = 62'(mb_q[j]) * 62'(mb_q[j]);
    assign ta = pa[61:30];
    assign tb = pb[61:30];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ma_q[j+1] <= ta[31] ? ta[31:1] : ta[30:0];
        mb_q[j+1] <= tb[31] ? tb[31:1] : tb[30:0];
        ra_q[j+1] <= ra_q[j] | (ta[31] ? (34'd1 << (LOG_STEPS - 1 - j)) : 34'd0);
        rb_q[j+1] <= rb_q[j] | (tb[31] ? (34'd1 << (LOG_STEPS - 1 - j)) : 34'd0);
      end
    end
  end

  // Stage: log difference as sign and magnitude
  logic        neg_q, neg2_q, neg3_q, neg4_q;
  logic [33:0] mag_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_q <= ra_q[LOG_STEPS] < rb_q[LOG_STEPS];
      mag_q <= (ra_q[LOG_STEPS] < rb_q[LOG_STEPS]) ? rb_q[LOG_STEPS] - ra_q[LOG_STEPS]
                                                   : ra_q[LOG_STEPS] - rb_q[LOG_STEPS];
    end
  end

  // Stage: times ln2, split in two partial products
  logic [46:0] pl_q, ph_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg2_q <= neg_q;
      pl_q   <= 47'(mag_q[16:0]) * 47'(LN2_Q30);
      ph_q   <= 47'(mag_q[33:17]) * 47'(LN2_Q30);
    end
  end

  // Stage: sum and round to Q.24
  logic [64:0] lsum;
  logic [30:0] lq_q;
  assign lsum = (65'(ph_q) << 17) + 65'(pl_q) + (65'd1 << 33);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg3_q <= neg2_q;
      lq_q   <= lsum[64:34];
    end
  end

  // Stage: T0 times log
  logic [46:0] tq_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg4_q <= neg3_q;
      tq_q   <= 47'(t0_q) * 47'(lq_q);
    end
  end

  // Stage: Beta denominator, dividend 2n+d and divisor 2d
  logic signed [48:0] dsum;
  logic [63:0] xdiv_q;
  logic [48:0] ddiv_q;
  logic        dbad_q;
  assign dsum = neg4_q ? $signed(49'(bterm_q)) - $signed(49'(tq_q))
                       : $signed(49'(bterm_q)) + $signed(49'(tq_q));
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dbad_q <= dsum[48] || (dsum == '0);
      xdiv_q <= {2'b0, n_q, 1'b0} + 64'(dsum[47:0]);
      ddiv_q <= {dsum[47:0], 1'b0};
    end
  end

  // Stage: quotient overflow check, seeds the kelvin divider
  logic [63:0] d2_rem_q [DIV2_STEPS+1];
  logic [16:0] d2_quo_q [DIV2_STEPS+1];
  logic        d2_ovf_q [DIV2_STEPS+1];
  logic        d2_bad_q [DIV2_STEPS+1];
  logic [48:0] d2_div_q [DIV2_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_rem_q[0] <= xdiv_q;
      d2_quo_q[0] <= '0;
      d2_ovf_q[0] <= 66'(xdiv_q) >= (66'(ddiv_q) << DIV2_STEPS);
      d2_bad_q[0] <= dbad_q;
      d2_div_q[0] <= ddiv_q;
    end
  end

  // Kelvin divider: one quotient bit per stage, MSB first; divisor travels along
  for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
    logic [65:0] sub;
    logic        take;
    assign sub  = 66'(d2_div_q[k]) << (DIV2_STEPS - 1 - k);
    assign take = 66'(d2_rem_q[k]) >= sub;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d2_rem_q[k+1] <= take ? 64'(66'(d2_rem_q[k]) - sub) : d2_rem_q[k];
        d2_quo_q[k+1] <= d2_quo_q[k] | (take ? (17'd1 << (DIV2_STEPS - 1 - k)) : 17'd0);
        d2_ovf_q[k+1] <= d2_ovf_q[k];
        d2_bad_q[k+1] <= d2_bad_q[k];
        d2_div_q[k+1] <= d2_div_q[k];
      end
    end
  end

  // Output stage: saturate and take off the kelvin offset
  logic [16:0] qk;
  logic        invalid;
  logic        over;
  logic [16:0] temp_d;
  logic signed [16:0] temp_q;
  logic        sat_q;

  assign qk      = d2_quo_q[DIV2_STEPS];
  assign invalid = cfg_bad_q || d2_bad_q[DIV2_STEPS];
  assign over    = d2_ovf_q[DIV2_STEPS] || (qk > TEMP_LIMIT);
  assign temp_d  = invalid ? 17'd0 : (over ? TEMP_HIGH : qk - KELVIN_OFFSET);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      temp_q <= $signed(temp_d);
      sat_q  <= invalid || over;
    end
  end

  assign temp_centi_celsius_o = temp_q;
  assign sample_millivolts_o  = mv_q[NUM_STAGES-1];
  assign ratio_clamped_o      = clamp_q[NUM_STAGES-1];
  assign result_saturated_o   = sat_q;

endmodule

// ===== design/thbt_chk.sv =====
// Port-level checker for the thermistor temperature pipeline, with its bind.
`timescale 1ns / 1ps
module thbt_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [16:0]              temp_centi_celsius_o,
  input logic [15:0]                     sample_millivolts_o,
  input logic                            ratio_clamped_o,
  input logic                            result_saturated_o
);

  // A held output word freezes the pipe, so no new word may enter
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output word is stalled");

  // A stalled result stays on the output
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temp_centi_celsius_o)
      && $stable(sample_millivolts_o) && $stable(ratio_clamped_o))
    else $error("stalled output word changed");

  // An unclamped ratio means a nonzero millivolt reading
  a_unclamped_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ratio_clamped_o |-> sample_millivolts_o != 16'd0)
    else $error("unclamped ratio with zero millivolts");

  // A normal result never falls below absolute zero
  a_temp_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_saturated_o |-> temp_centi_celsius_o >= -17'sd27315)
    else $error("temperature below absolute zero");

endmodule

bind thermistor_beta_temperature_top thbt_chk u_thbt_chk (.*);
